// ----- sv/hwc_pkg.sv -----
package hwc_pkg;

	localparam int unsigned TS_W      = 31;
	localparam int unsigned WIN_W     = 16;
	localparam int unsigned COUNT_W   = 11;

	localparam logic [WIN_W-1:0]   WINDOW_RESET = 16'd300;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 11'h7FF;

	localparam logic OP_HIT   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_PRUNE = 2'b10
	} state_t;

endpackage

// ----- sv/hwc_stamp_ram.sv -----
module hwc_stamp_ram #(
	parameter int unsigned DEPTH  = 1024,
	parameter int unsigned ADDR_W = 10
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          waddr,
	input  logic [hwc_pkg::TS_W-1:0]   wdata,
	input  logic [ADDR_W-1:0]          raddr,
	output logic [hwc_pkg::TS_W-1:0]   rdata
);

	logic [hwc_pkg::TS_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-first on a same-address collision so the head word is never stale
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/sliding_window_hit_counter.sv -----
// Channel  | Dir | tdata (low bit up)              | tuser
// s_axis   | in  | timestamp[30:0], pad[31]        | operation (0 hit, 1 query)
// m_axis   | out | hits_in_window[10:0], pad[15:11]| hit_dropped
// cfg      | in  | cfg_wdata = window_length[15:0] | -
//
// An item is accepted in ST_IDLE; ST_PRUNE then examines the head entry, one
// per cycle, popping each expired one until the head is live, and finishes;
// the pops are paced by the single read port of the timestamp RAM.
// Reset clears the pointers and the count and sets the window register to
// WINDOW_RESET; the RAM is not cleared, only written entries are ever read.
// A result waits in the output register; the next beat is accepted while it
// waits, and the block stalls only when a second result is ready.
module sliding_window_hit_counter #(
	parameter int unsigned FIFO_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [30:0] timestamp, [31] zero
	input  logic [0:0]  s_axis_tuser,   // [0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [10:0] hits_in_window, [15:11] zero
	output logic [0:0]  m_axis_tuser,   // [0] hit_dropped
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata       // window_length
);

	localparam int unsigned IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > hwc_pkg::COUNT_W) ? CNT_W : hwc_pkg::COUNT_W;

	hwc_pkg::state_t state_q;

	logic [hwc_pkg::WIN_W-1:0] window_q;
	logic [IDX_W-1:0]          head_q;
	logic [IDX_W-1:0]          tail_q;
	logic [CNT_W-1:0]          count_q;
	logic                      op_q;
	logic [hwc_pkg::TS_W-1:0]  ts_q;

	logic                         out_valid_q;
	logic [hwc_pkg::COUNT_W-1:0]  out_count_q;
	logic                         out_drop_q;

	logic [hwc_pkg::TS_W-1:0]  head_ts;
	logic [IDX_W-1:0]          head_d;
	logic [IDX_W-1:0]          head_inc;
	logic [IDX_W-1:0]          tail_inc;
	logic [hwc_pkg::WIN_W-1:0] span;
	logic [hwc_pkg::TS_W-1:0]  age;
	logic                      expired;
	logic                      pop;
	logic                      finish;
	logic                      full;
	logic                      push;
	logic                      accept;
	logic [CNT_W-1:0]          count_after;
	logic [hwc_pkg::COUNT_W-1:0] shown;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == hwc_pkg::ST_IDLE);

	// a zero window behaves as a window of one
	assign span = (window_q == '0) ? hwc_pkg::WIN_W'(1) : window_q;
	assign age  = ts_q - head_ts;

	// a head stamp later than now never expires
	assign expired = (count_q != '0) && (ts_q >= head_ts) &&
		(age >= hwc_pkg::TS_W'(span));

	assign pop    = (state_q == hwc_pkg::ST_PRUNE) && expired;
	assign finish = (state_q == hwc_pkg::ST_PRUNE) && !expired &&
		(!out_valid_q || m_axis_tready);
	assign full   = (count_q == CNT_W'(FIFO_DEPTH));
	assign push   = finish && (op_q == hwc_pkg::OP_HIT) && !full;

	assign head_inc = (head_q == IDX_W'(FIFO_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
	assign tail_inc = (tail_q == IDX_W'(FIFO_DEPTH - 1)) ? '0 : tail_q + IDX_W'(1);
	assign head_d   = pop ? head_inc : head_q;

	// keep the RAM output tracking the head entry, one pop per cycle
	hwc_stamp_ram #(
		.DEPTH  (FIFO_DEPTH),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (push),
		.waddr (tail_q),
		.wdata (ts_q),
		.raddr (head_d),
		.rdata (head_ts)
	);

	assign count_after = push ? count_q + CNT_W'(1) : count_q;
	assign shown = (CMP_W'(count_after) > CMP_W'(hwc_pkg::COUNT_MAX)) ?
		hwc_pkg::COUNT_MAX : hwc_pkg::COUNT_W'(count_after);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= hwc_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// sequencer: accept, then examine the head until it is live, then finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hwc_pkg::ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				hwc_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= hwc_pkg::ST_PRUNE;
					end
				end
				hwc_pkg::ST_PRUNE: begin
					if (pop) begin
						head_q  <= head_inc;
						count_q <= count_q - CNT_W'(1);
					end else if (finish) begin
						state_q <= hwc_pkg::ST_IDLE;
						count_q <= count_after;
						if (push) begin
							tail_q <= tail_inc;
						end
					end
				end
				default: begin
					state_q <= hwc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// hold the beat's payload for the whole item
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= s_axis_tuser[0];
			ts_q <= s_axis_tdata[hwc_pkg::TS_W-1:0];
		end
	end

	// output register: drop the beat once taken, load a fresh result on finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_count_q <= shown;
			out_drop_q  <= (op_q == hwc_pkg::OP_HIT) && full;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_count_q};
	assign m_axis_tuser  = out_drop_q;

endmodule

// ----- sv/hwc_checker.sv -----
module hwc_checker #(
	parameter int unsigned FIFO_DEPTH = 1024
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic [0:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser,
	input logic        cfg_we,
	input logic [15:0] cfg_wdata
);

	localparam logic [10:0] SHOWN_FULL = (FIFO_DEPTH > 2047) ? 11'h7FF : 11'(FIFO_DEPTH);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// a dropped hit only happens with the store full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[10:0] == SHOWN_FULL)
		else $error("hit dropped while store not full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[10:0] <= SHOWN_FULL && m_axis_tdata[15:11] == 5'b0)
		else $error("count beyond store depth");

	// one beat in, at most one ready slot: no new beat taken the cycle after one
	a_in_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while an item is still in progress");

	logic unused_ok;
	assign unused_ok = ^{s_axis_tdata, s_axis_tuser, cfg_we, cfg_wdata};

endmodule

bind sliding_window_hit_counter hwc_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_hwc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.cfg_we        (cfg_we),
	.cfg_wdata     (cfg_wdata)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int unsigned FIFO_DEPTH  = 1024;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned MAX_REPORTS = 10;
	// Latest timestamp the field can carry, and the ceiling for ordinary traffic:
	// anything at or below the ceiling has expired by the time a query at the top
	// arrives, whatever the window.
	localparam int unsigned TS_TOP      = 32'h7FFF_FFFF;
	localparam int unsigned TS_CEIL     = TS_TOP - (1 << 17);

	typedef struct packed {
		logic                     op;
		logic [hwc_pkg::TS_W-1:0] stamp;
	} hit_beat_t;

	typedef struct packed {
		logic [hwc_pkg::COUNT_W-1:0] hits;
		logic                        dropped;
	} tally_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;   // [30:0] timestamp, [31] zero
	logic [0:0]  s_axis_tuser  = '0;   // [0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;         // [10:0] hits_in_window, [15:11] zero
	logic [0:0]  m_axis_tuser;         // [0] hit_dropped
	logic        cfg_we        = 1'b0;
	logic [15:0] cfg_wdata     = '0;

	// Shadow of the block: live hit stamps, oldest first, and the window register.
	logic [hwc_pkg::TS_W-1:0]  live_stamps[$];
	logic [hwc_pkg::WIN_W-1:0] window_len = hwc_pkg::WINDOW_RESET;

	tally_t    expected_tallies[$];
	hit_beat_t pending_beats[$];
	tally_t    oldest_tally;
	hit_beat_t next_beat;

	int unsigned beats_queued   = 0;
	int unsigned beats_taken    = 0;
	int unsigned error_count    = 0;
	int unsigned cycle_count    = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned rx_hold_left   = 0;
	bit          last_beat_accepted = 1'b0;

	sliding_window_hit_counter #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Work out the result of one accepted beat and advance the shadow state.
	// Expire from the head while the oldest stamp is at least a window old; a
	// stamp later than the current time is never expired, so pruning stops there.
	function automatic tally_t count_window_hits(logic op, logic [hwc_pkg::TS_W-1:0] now);
		int unsigned span;
		tally_t      tally;
		span = (window_len == '0) ? 1 : window_len;
		while (live_stamps.size() > 0 && now >= live_stamps[0] &&
				(32'(now) - 32'(live_stamps[0])) >= span)
			live_stamps.delete(0);
		tally.dropped = 1'b0;
		if (op == hwc_pkg::OP_HIT) begin
			// A full store loses the hit and flags it
			if (live_stamps.size() >= FIFO_DEPTH)
				tally.dropped = 1'b1;
			else
				live_stamps.insert(live_stamps.size(), now);
		end
		tally.hits = (live_stamps.size() > hwc_pkg::COUNT_MAX) ? hwc_pkg::COUNT_MAX :
			hwc_pkg::COUNT_W'(live_stamps.size());
		return tally;
	endfunction

	task automatic flag_mismatch(string field, int unsigned want, int unsigned got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, field, want, got);
	endtask

	// Monitor: track the window register, predict every accepted input beat and
	// check every accepted output beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_stamps.delete();
			window_len = hwc_pkg::WINDOW_RESET;
		end else begin
			if (cfg_we)
				window_len = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				expected_tallies.insert(expected_tallies.size(),
						count_window_hits(s_axis_tuser[0],
						s_axis_tdata[hwc_pkg::TS_W-1:0]));
				beats_taken++;
				last_beat_accepted = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_tallies.size() == 0) begin
					flag_mismatch("unexpected result beat", 0, m_axis_tdata);
				end else begin
					oldest_tally = expected_tallies[0];
					expected_tallies.delete(0);
					// Compare the whole tdata so that the pad bits must be zero too
					if (m_axis_tdata !== {{(16-hwc_pkg::COUNT_W){1'b0}}, oldest_tally.hits})
						flag_mismatch("hits_in_window", oldest_tally.hits, m_axis_tdata);
					if (m_axis_tuser[0] !== oldest_tally.dropped)
						flag_mismatch("hit_dropped", oldest_tally.dropped, m_axis_tuser[0]);
				end
			end
		end
	end

	// Driver: offer the next pending beat once the current one has gone, or
	// idle at random; hold a beat unchanged until it is taken.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || last_beat_accepted)) begin
			last_beat_accepted = 1'b0;
			if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next_beat = pending_beats[0];
				pending_beats.delete(0);
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {1'b0, next_beat.stamp};
				s_axis_tuser  <= next_beat.op;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: stall at random, and hold off entirely while a long hold runs.
	always @(negedge clk) begin
		m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	// Count the long receiver hold down at each rising clock edge.
	always @(posedge clk) begin
		if (rx_hold_left > 0)
			rx_hold_left--;
	end

	// Watchdog: end the run if it fails to drain in time.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic queue_beat(input logic op, input int unsigned stamp);
		hit_beat_t beat;
		beat.op    = op;
		beat.stamp = hwc_pkg::TS_W'(stamp);
		pending_beats.insert(pending_beats.size(), beat);
		beats_queued++;
	endtask

	// Wait until every queued beat is taken and every result has come back.
	task automatic wait_idle();
		while (beats_taken != beats_queued || expected_tallies.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_window(input logic [hwc_pkg::WIN_W-1:0] win);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= win;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// One random phase: set the window while idle, then mostly advance time in
	// small steps (if wild, with the odd backward step or large jump), and finish
	// with a query at the top timestamp so the next phase starts with an empty store.
	task automatic run_phase(input logic [hwc_pkg::WIN_W-1:0] win,
			input int unsigned idle_pct,
			input int unsigned stall_pct, input int unsigned n_items,
			input int unsigned hit_pct, input int unsigned step_max, input bit wild,
			input int unsigned hold);
		int unsigned span;
		int unsigned stamp;
		int unsigned roll;
		int unsigned back;
		span = (win == '0) ? 1 : win;
		wait_idle();
		write_window(win);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		rx_hold_left   = hold;
		stamp = $urandom_range(TS_CEIL - (1 << 22), 0);
		repeat (n_items) begin
			roll = $urandom_range(99);
			if (wild && roll < 4) begin
				back  = $urandom_range(2 * span, 0);
				stamp = (back > stamp) ? 0 : stamp - back;
			end else if (wild && roll < 7) begin
				stamp += $urandom_range(1 << 20, 0);
			end else begin
				stamp += $urandom_range(step_max, 0);
			end
			if (stamp > TS_CEIL)
				stamp = TS_CEIL;
			queue_beat(($urandom_range(99) < hit_pct) ? hwc_pkg::OP_HIT : hwc_pkg::OP_QUERY,
				stamp);
		end
		queue_beat(hwc_pkg::OP_QUERY, TS_TOP);
	endtask

	initial begin
		logic [hwc_pkg::WIN_W-1:0] rand_win;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed beats under the reset window of 300: expiry exactly at the
		// window edge, stamps going backwards, and a query at the top timestamp.
		queue_beat(hwc_pkg::OP_HIT,   0);
		queue_beat(hwc_pkg::OP_QUERY, 0);
		queue_beat(hwc_pkg::OP_HIT,   0);
		queue_beat(hwc_pkg::OP_HIT,   299);
		queue_beat(hwc_pkg::OP_QUERY, 299);
		queue_beat(hwc_pkg::OP_QUERY, 300);
		queue_beat(hwc_pkg::OP_HIT,   598);
		queue_beat(hwc_pkg::OP_QUERY, 599);
		queue_beat(hwc_pkg::OP_QUERY, 897);
		queue_beat(hwc_pkg::OP_QUERY, 898);
		queue_beat(hwc_pkg::OP_HIT,   1000);
		queue_beat(hwc_pkg::OP_HIT,   1000);
		queue_beat(hwc_pkg::OP_QUERY, 500);
		queue_beat(hwc_pkg::OP_HIT,   700);
		queue_beat(hwc_pkg::OP_QUERY, 1299);
		queue_beat(hwc_pkg::OP_QUERY, 1300);
		queue_beat(hwc_pkg::OP_QUERY, TS_TOP);

		// Zero window (treated as one), then the narrowest real window.
		run_phase(16'd0, 0, 0, 30, 70, 1, 1'b1, 0);
		run_phase(16'd1, 52, 0, 30, 70, 2, 1'b1, 0);

		rand_win = hwc_pkg::WIN_W'($urandom_range(400, 2));
		run_phase(rand_win, 0, 52, 30, 65, rand_win / 4 + 1, 1'b1, 0);
		run_phase(16'd20, 27, 27, 30, 60, 6, 1'b1, 0);

		// Widest window with slowly advancing time: fill the store until hits drop.
		// Hold the receiver off at the start so that the block backs up onto its input.
		run_phase(16'hFFFF, 0, 0, 1150, 97, 1, 1'b0, 400);

		run_phase(16'd300, 27, 27, 30, 75, 90, 1'b1, 0);

		// Hit at the top timestamp, then a query far in the past: the head stamp
		// lies in the future and must stay counted.
		wait_idle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		queue_beat(hwc_pkg::OP_HIT,   TS_TOP);
		queue_beat(hwc_pkg::OP_QUERY, TS_TOP);
		queue_beat(hwc_pkg::OP_QUERY, 0);

		wait_idle();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
